@@ src/modbus_response_checker_defines.svh @@
// assertion macros for the modbus response checker
// no dependencies; included by the top level, which supplies clk and arst_n
`ifndef MODBUS_RESPONSE_CHECKER_DEFINES_SVH
`define MODBUS_RESPONSE_CHECKER_DEFINES_SVH

`ifndef SYNTHESIS

// implication checked in the same cycle
`define MRC_ASSERT_SAME(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// implication checked in the next cycle
`define MRC_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define MRC_ASSERT_SAME(name, ante, cons, msg)
`define MRC_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

@@ src/mrc_pkg.sv @@
// shared types and constants for the modbus response checker
// no dependencies; used by the interfaces and all modules
package mrc_pkg;

	localparam int MAX_FRAME_BYTES = 256;
	localparam int HDR_BYTES       = 6;
	localparam int LEN_W           = $clog2(MAX_FRAME_BYTES + 1);
	localparam int IDX_W           = $clog2(HDR_BYTES + 1);

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_EXCEPTION = 3'd1;
	localparam logic [2:0] ST_MALFORMED = 3'd2;
	localparam logic [2:0] ST_BAD_SLAVE = 3'd3;
	localparam logic [2:0] ST_FUNC_CODE = 3'd4;
	localparam logic [2:0] ST_EXC_OVER  = 3'd5;

	// standard function codes and the exception flag
	localparam logic [7:0] FC_RD_COILS         = 8'd1;
	localparam logic [7:0] FC_READ_DISCRETE    = 8'd2;
	localparam logic [7:0] FC_READ_HOLDING     = 8'd3;
	localparam logic [7:0] FC_READ_INPUT_REGS  = 8'd4;
	localparam logic [7:0] FC_WRITE_COIL       = 8'd5;
	localparam logic [7:0] FC_WRITE_REG        = 8'd6;
	localparam logic [7:0] FC_EXC_STATUS       = 8'd7;
	localparam logic [7:0] FC_DIAG             = 8'd8;
	localparam logic [7:0] FC_EVENT_COUNTER    = 8'd11;
	localparam logic [7:0] FC_EVENT_LOG        = 8'd12;
	localparam logic [7:0] FC_WRITE_COILS      = 8'd15;
	localparam logic [7:0] FC_WRITE_REGS       = 8'd16;
	localparam logic [7:0] FC_SERVER_ID        = 8'd17;
	localparam logic [7:0] FC_READ_FILE        = 8'd20;
	localparam logic [7:0] FC_WRITE_FILE       = 8'd21;
	localparam logic [7:0] FC_MASK_WRITE       = 8'd22;
	localparam logic [7:0] FC_RW_REGS          = 8'd23;
	localparam logic [7:0] FC_READ_FIFO        = 8'd24;
	localparam logic [7:0] EXC_FLAG            = 8'h80;

	typedef struct packed {
		logic       action;
		logic [7:0] data_byte;
		logic       first_byte;
		logic       last_byte;
	} item_t;

	typedef struct packed {
		logic [2:0] status;
		logic [6:0] exception_code;
		logic       is_exception;
	} result_t;

	// header bytes and length as they stand after the current byte
	typedef struct packed {
		logic [HDR_BYTES-1:0][7:0] rq;
		logic [HDR_BYTES-1:0][7:0] rs;
		logic [LEN_W-1:0]          len;
	} frame_view_t;

endpackage

@@ src/mrc_item_if.sv @@
// frame byte channel (valid/ready) for the modbus response checker
// depends on mrc_pkg
interface mrc_item_if;
	import mrc_pkg::*;

	logic  valid;
	logic  ready;
	item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);

endinterface

@@ src/mrc_result_if.sv @@
// check result channel (valid/ready) for the modbus response checker
// depends on mrc_pkg
interface mrc_result_if;
	import mrc_pkg::*;

	logic    valid;
	logic    ready;
	result_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);

endinterface

@@ src/modbus_response_checker.sv @@
// modbus response checker: one frame byte per cycle, back to back unless a result stalls
// the last response byte passes through the input register, and the result register loads
// from the rule check as that byte leaves the input register; throughput: one byte each
// cycle while results are taken; a stalled result holds the input only once the next
// last response byte sits in the input register
// reset (arst_n low) clears both header stores, the byte counts and all valid flags
`include "modbus_response_checker_defines.svh"

module modbus_response_checker (
	input  logic                clk,
	input  logic                arst_n,
	mrc_item_if.sink            items,
	mrc_result_if.source        results
);
	import mrc_pkg::*;

	logic        valid_s1;
	item_t       item_s1;
	logic        adv_s1;
	logic        makes_result_s1;
	frame_view_t view;
	result_t     res_d;
	logic        out_valid_q;
	result_t     out_q;

	// only a last response byte needs room in the result register
	assign makes_result_s1 = item_s1.action && item_s1.last_byte;
	assign adv_s1 = valid_s1 && (!makes_result_s1 || !out_valid_q || results.ready);
	assign items.ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (items.ready) begin
			valid_s1 <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (items.ready && items.valid)
			item_s1 <= items.payload;
	end

	mrc_frame_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (adv_s1),
		.item   (item_s1),
		.view   (view)
	);

	mrc_rule_check u_check (
		.view (view),
		.res  (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1 && makes_result_s1) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && makes_result_s1)
			out_q <= res_d;
	end

	assign results.valid   = out_valid_q;
	assign results.payload = out_q;

	`MRC_ASSERT_SAME(a_exc_flag, results.valid && results.payload.status == ST_EXCEPTION, results.payload.is_exception, "exception status without exception flag")
	`MRC_ASSERT_SAME(a_exc_code, results.valid && results.payload.status != ST_EXCEPTION, results.payload.exception_code == 7'd0, "exception code set outside exception status")
	`MRC_ASSERT_SAME(a_status_range, results.valid, results.payload.status <= ST_EXC_OVER, "status code out of range")
	`MRC_ASSERT_NEXT(a_no_spurious, !(adv_s1 && makes_result_s1) && !(results.valid && !results.ready), !results.valid, "result without a last response byte")

endmodule

@@ src/mrc_frame_store.sv @@
// header capture and byte counting for request and response frames
// depends on mrc_pkg; shows the state as updated by the current byte
module mrc_frame_store (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                upd,
	input  mrc_pkg::item_t      item,
	output mrc_pkg::frame_view_t view
);
	import mrc_pkg::*;

	logic [HDR_BYTES-1:0][7:0] rq_q;
	logic [HDR_BYTES-1:0][7:0] rs_q;
	logic [LEN_W-1:0]          len_q;
	logic [IDX_W-1:0]          rq_cnt_q;

	logic [IDX_W-1:0]          rq_base;
	logic [LEN_W-1:0]          rs_base;
	logic [IDX_W-1:0]          rq_cnt_d;
	logic [LEN_W-1:0]          len_d;
	logic [HDR_BYTES-1:0][7:0] rq_d;
	logic [HDR_BYTES-1:0][7:0] rs_d;

	always_comb begin
		rq_base  = item.first_byte ? '0 : rq_cnt_q;
		rs_base  = item.first_byte ? '0 : len_q;
		rq_d     = rq_q;
		rs_d     = rs_q;
		rq_cnt_d = rq_cnt_q;
		len_d    = len_q;
		if (!item.action) begin
			rq_cnt_d = rq_base;
			if (rq_base < IDX_W'(HDR_BYTES)) begin
				rq_d[rq_base[IDX_W-1:0]] = item.data_byte;
				rq_cnt_d = rq_base + 1'b1;
			end
		end else begin
			len_d = rs_base;
			if (rs_base < LEN_W'(HDR_BYTES))
				rs_d[rs_base[IDX_W-1:0]] = item.data_byte;
			// count saturates at the frame limit
			if (rs_base < LEN_W'(MAX_FRAME_BYTES))
				len_d = rs_base + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rq_q     <= '0;
			rs_q     <= '0;
			len_q    <= '0;
			rq_cnt_q <= '0;
		end else if (upd) begin
			rq_q     <= rq_d;
			rs_q     <= rs_d;
			len_q    <= len_d;
			rq_cnt_q <= rq_cnt_d;
		end
	end

	assign view.rq  = rq_d;
	assign view.rs  = rs_d;
	assign view.len = len_d;

endmodule

@@ src/mrc_rule_check.sv @@
// response-against-request rules, producing one status word
// depends on mrc_pkg; purely combinational
module mrc_rule_check (
	input  mrc_pkg::frame_view_t view,
	output mrc_pkg::result_t     res
);
	import mrc_pkg::*;

	localparam int CMP_W = 18;

	logic [7:0]       fc;
	logic [7:0]       bc;
	logic [15:0]      qty;
	logic [16:0]      qty_p7;
	logic [CMP_W-1:0] len_x;
	logic [CMP_W-1:0] bit_bytes;
	logic [CMP_W-1:0] reg_bytes;
	logic [CMP_W-1:0] len_from_bc;
	logic [CMP_W-1:0] fifo_len;
	logic [CMP_W-1:0] fifo_cnt_len;
	logic             echo6;
	logic             echo4;
	logic [2:0]       status;
	logic [6:0]       exc;

	always_comb begin
		fc           = view.rs[1];
		bc           = view.rs[2];
		qty          = {view.rq[4], view.rq[5]};
		qty_p7       = {1'b0, qty} + 17'd7;
		len_x        = CMP_W'(view.len);
		bit_bytes    = CMP_W'(qty_p7[16:3]);
		reg_bytes    = CMP_W'({qty, 1'b0});
		len_from_bc  = CMP_W'(bc) + CMP_W'(3);
		fifo_len     = reg_bytes + CMP_W'(6);
		fifo_cnt_len = CMP_W'({view.rs[2], view.rs[3]}) + CMP_W'(4);
		echo4        = (view.rq[3:0] == view.rs[3:0]);
		echo6        = echo4 && (view.rq[5:4] == view.rs[5:4]);

		status = ST_OK;
		exc    = '0;
		if (len_x < CMP_W'(3)) begin
			status = ST_MALFORMED;
		end else if (view.rs[0] != view.rq[0] || view.rs[0] == 8'd0) begin
			status = ST_BAD_SLAVE;
		end else if ({1'b0, fc[6:0]} != view.rq[1]) begin
			status = ST_FUNC_CODE;
		end else if (fc[7]) begin
			if (!bc[7]) begin
				exc    = bc[6:0];
				status = (bc == 8'd0) ? ST_OK : ST_EXCEPTION;
			end else begin
				status = ST_EXC_OVER;
			end
		end else begin
			case (fc) inside
				FC_RD_COILS, FC_READ_DISCRETE: begin
					if (CMP_W'(bc) != bit_bytes || len_x != len_from_bc)
						status = ST_MALFORMED;
				end
				FC_READ_HOLDING, FC_READ_INPUT_REGS, FC_RW_REGS: begin
					if (CMP_W'(bc) != reg_bytes || len_x != len_from_bc)
						status = ST_MALFORMED;
				end
				FC_WRITE_COIL, FC_WRITE_REG, FC_WRITE_COILS, FC_WRITE_REGS: begin
					if (len_x != CMP_W'(6) || !echo6)
						status = ST_MALFORMED;
				end
				FC_EXC_STATUS: begin
					if (len_x != CMP_W'(3))
						status = ST_MALFORMED;
				end
				FC_DIAG: begin
					if (len_x < CMP_W'(6) || !echo4)
						status = ST_MALFORMED;
				end
				FC_EVENT_COUNTER: begin
					if (len_x != CMP_W'(6))
						status = ST_MALFORMED;
				end
				FC_EVENT_LOG: begin
					if (len_x < CMP_W'(9) || len_x != len_from_bc)
						status = ST_MALFORMED;
				end
				FC_SERVER_ID: begin
					if (len_x < CMP_W'(5))
						status = ST_MALFORMED;
				end
				FC_MASK_WRITE: begin
					if (len_x != CMP_W'(8) || !echo6)
						status = ST_MALFORMED;
				end
				FC_READ_FIFO: begin
					if (len_x != fifo_len || len_x != fifo_cnt_len)
						status = ST_MALFORMED;
				end
				default: status = ST_FUNC_CODE;
			endcase
		end
	end

	assign res.status         = status;
	assign res.exception_code = (status == ST_EXCEPTION) ? exc : 7'd0;
	assign res.is_exception   = (view.len >= LEN_W'(2)) && view.rs[1][7];

endmodule
